### src/frb_pkg.sv
// Shared types and constants for the frame ring buffer.
`default_nettype none
package frb_pkg;

    // Default sizes of the frame store.
    localparam int MAX_FRAME_BYTES_DEF = 4096;
    localparam int MAX_SLOTS_DEF       = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int FRAMES_KEPT_W = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_BYTES = 2'd0,
        CFG_FRAMES_KEPT = 2'd1
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0]    FRAME_BYTES_RESET = 13'd1024;
    localparam logic [FRAMES_KEPT_W-1:0] FRAMES_KEPT_RESET = 4'd15;

    // Word actions.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Per-word request from the pointer control to the store and output stage.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic frame_end;
        logic underrun;
    } frb_req_t;

endpackage
`default_nettype wire

### src/frb_store.sv
// Single-port byte store holding the frame slots, with a registered read.
`default_nettype none
module frb_store #(
    parameter int ADDR_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [7:0]        wr_data,
    output logic [7:0]             rd_data
);
    localparam int DEPTH = 2 ** ADDR_W;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    // Read register holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### src/frb_ctrl.sv
// Slot and offset pointers, fill count and underrun tracking for the frame ring.
`default_nettype none
module frb_ctrl #(
    parameter int OFF_W  = 12,
    parameter int SLOT_W = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      clear,
    input  wire logic                      fire,
    input  wire logic                      action,
    input  wire logic [OFF_W-1:0]          fb_last,
    input  wire logic [SLOT_W-1:0]         slot_last,
    output logic [SLOT_W+OFF_W-1:0]        addr,
    output frb_pkg::frb_req_t              req
);
    import frb_pkg::*;

    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [SLOT_W-1:0] filled_reg, filled_next;
    logic [OFF_W-1:0]  woff_reg, woff_next;
    logic [OFF_W-1:0]  roff_reg, roff_next;
    logic              und_reg, und_next;

    logic und_now;
    logic w_last;
    logic r_last;

    // Switching action resets the other side's offset, so the offsets
    // held here are already the ones in force.
    assign w_last  = (woff_reg == fb_last);
    assign r_last  = (roff_reg == fb_last);
    assign und_now = (roff_reg == '0) ? (filled_reg == '0) : und_reg;

    always_comb begin
        wslot_next  = wslot_reg;
        rslot_next  = rslot_reg;
        filled_next = filled_reg;
        woff_next   = woff_reg;
        roff_next   = roff_reg;
        und_next    = und_reg;
        req         = '0;
        addr        = {rslot_reg, roff_reg};

        if (fire) begin
            if (action == ACT_WRITE) begin
                addr      = {wslot_reg, woff_reg};
                req.wr_en = 1'b1;
                roff_next = '0;
                und_next  = 1'b0;
                if (w_last) begin
                    woff_next  = '0;
                    wslot_next = (wslot_reg == slot_last) ? '0 : wslot_reg + 1'b1;
                    if (filled_reg == slot_last) begin
                        // full: drop oldest frame
                        rslot_next  = (rslot_reg == slot_last) ? '0 : rslot_reg + 1'b1;
                        filled_next = slot_last;
                    end else begin
                        filled_next = filled_reg + 1'b1;
                    end
                end else begin
                    woff_next = woff_reg + 1'b1;
                end
            end else begin
                req.rd_en     = 1'b1;
                req.frame_end = r_last;
                req.underrun  = und_now;
                woff_next     = '0;
                und_next      = und_now;
                if (r_last) begin
                    roff_next = '0;
                    if (!und_now) begin
                        rslot_next = (rslot_reg == slot_last) ? '0 : rslot_reg + 1'b1;
                        if (filled_reg != '0) begin
                            filled_next = filled_reg - 1'b1;
                        end
                    end
                end else begin
                    roff_next = roff_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            wslot_reg  <= '0;
            rslot_reg  <= '0;
            filled_reg <= '0;
            woff_reg   <= '0;
            roff_reg   <= '0;
            und_reg    <= 1'b0;
        end else begin
            wslot_reg  <= wslot_next;
            rslot_reg  <= rslot_next;
            filled_reg <= filled_next;
            woff_reg   <= woff_next;
            roff_reg   <= roff_next;
            und_reg    <= und_next;
        end
    end

endmodule
`default_nettype wire

### src/frame_ring_buffer_overwrite.sv
// Top level of the overwriting audio frame ring buffer.
// Result: a read word's result is presented in the cycle after it is accepted.
// Throughput: one word per cycle, limited by the single port of the byte store;
//   s_ready drops only while a result waits on m_ready.
// Reset: pointers, offsets, fill count, configuration registers and m_valid return to
//   their defaults at once; there is no clearing pass and store contents are undefined until written.
`default_nettype none
module frame_ring_buffer_overwrite #(
    parameter int MAX_FRAME_BYTES = frb_pkg::MAX_FRAME_BYTES_DEF,
    parameter int MAX_SLOTS       = frb_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [frb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [frb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input words
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_action,
    input  wire logic [7:0]                     s_data,
    // result words
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_read_byte,
    output logic                                m_frame_end,
    output logic                                m_underrun
);
    import frb_pkg::*;

    // Byte offset and slot widths; the store is addressed as {slot, offset}.
    localparam int OFF_W  = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int ADDR_W = SLOT_W + OFF_W;

    // Configuration registers, raw as written.
    logic [CFG_DATA_W-1:0]    frame_bytes_reg;
    logic [FRAMES_KEPT_W-1:0] frames_kept_reg;

    logic cfg_fire;
    logic cfg_hit;

    // Effective last offset and last slot index.
    logic [OFF_W-1:0]  fb_last;
    logic [SLOT_W-1:0] slot_last;

    logic              in_fire;
    frb_req_t          req;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        rd_data;

    // Output stage; the read byte itself stays in the store's read register.
    logic m_valid_reg, m_valid_next;
    logic frame_end_reg;
    logic underrun_reg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_fire && ((cfg_index == CFG_FRAME_BYTES) ||
                                    (cfg_index == CFG_FRAMES_KEPT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bytes_reg <= FRAME_BYTES_RESET;
            frames_kept_reg <= FRAMES_KEPT_RESET;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_FRAME_BYTES: frame_bytes_reg <= cfg_data;
                CFG_FRAMES_KEPT: frames_kept_reg <= cfg_data[FRAMES_KEPT_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero bytes acts as one; large values saturate to the store's frame size.
    always_comb begin
        if (frame_bytes_reg == '0) begin
            fb_last = '0;
        end else if (32'(frame_bytes_reg) > MAX_FRAME_BYTES) begin
            fb_last = OFF_W'(MAX_FRAME_BYTES - 1);
        end else begin
            fb_last = OFF_W'(32'(frame_bytes_reg) - 32'd1);
        end
    end

    // Slot count is frames_kept + 1, saturated to the number of slots built.
    always_comb begin
        if (32'(frames_kept_reg) > MAX_SLOTS - 1) begin
            slot_last = SLOT_W'(MAX_SLOTS - 1);
        end else begin
            slot_last = SLOT_W'(frames_kept_reg);
        end
    end

    // A new word enters whenever the output slot is free or being emptied.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    frb_ctrl #(
        .OFF_W  (OFF_W),
        .SLOT_W (SLOT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cfg_hit),
        .fire      (in_fire),
        .action    (s_action),
        .fb_last   (fb_last),
        .slot_last (slot_last),
        .addr      (addr),
        .req       (req)
    );

    frb_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .rd_en   (req.rd_en),
        .addr    (addr),
        .wr_data (s_data),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (req.rd_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            frame_end_reg <= req.frame_end;
            underrun_reg  <= req.underrun;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_byte = underrun_reg ? 8'd0 : rd_data;
    assign m_frame_end = frame_end_reg;
    assign m_underrun  = underrun_reg;

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the overwriting audio frame ring buffer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frb_pkg::*;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int unsigned FRAME_CAP    = MAX_FRAME_BYTES_DEF;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 2'd3; // no register behind it
    localparam int unsigned RANDOM_WORDS = 400;
    localparam int unsigned BIG_PART     = 30;   // words per partial frame at large lengths
    localparam int unsigned CALM_TAIL    = 100;  // last words of the run go without idling
    localparam int unsigned PLAN_ROWS    = 32;
    localparam int unsigned MAX_REPORTS  = 40;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_action  = ACT_WRITE;
    logic [7:0]             s_data    = 8'h00;
    logic                   m_ready   = 1'b0;
    wire logic              cfg_ready;
    wire logic              s_ready;
    wire logic              m_valid;
    wire logic [7:0]        m_read_byte;
    wire logic              m_frame_end;
    wire logic              m_underrun;

    frame_ring_buffer_overwrite dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_byte (m_read_byte),
        .m_frame_end (m_frame_end),
        .m_underrun  (m_underrun)
    );

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    // One result word as the block should present it.
    typedef struct packed {
        logic [7:0] rd_byte;
        logic       fend;
        logic       under;
    } read_word_t;

    typedef enum bit { ROW_WORD, ROW_REG } row_kind_t;

    // One row of the directed plan: either an input word or a register write.
    // Reads with typed = 1 carry their expected result in x_word.
    typedef struct packed {
        row_kind_t              kind;
        logic                   act;
        logic [7:0]             data;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        bit                     typed;
        read_word_t             x_word;
    } plan_row_t;

    // ------------------------------------------------------------------
    // Predicted buffer state
    // ------------------------------------------------------------------
    logic [7:0]               ring_mem [0:65535]; // {slot, offset}; never read unwritten
    logic [CFG_DATA_W-1:0]    fb_reg;
    logic [FRAMES_KEPT_W-1:0] fk_reg;
    logic [3:0]               wr_slot, rd_slot, filled;
    logic [11:0]              wr_off, rd_off;
    logic                     rd_under, prev_act;

    read_word_t  expected_reads [$];   // reads accepted, result not yet seen

    // Bookkeeping
    int unsigned errors    = 0;
    int unsigned n_words   = 0;
    int unsigned n_checked = 0;
    int unsigned n_under   = 0;
    int unsigned n_regs    = 0;
    int unsigned quiet_left = 0;
    bit          calm      = 1'b0;    // set: no idling on either side

    plan_row_t   plan [PLAN_ROWS];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Effective frame length: zero acts as one byte, large values saturate.
    function automatic int unsigned frame_len();
        if (fb_reg == 0) return 1;
        if (fb_reg > FRAME_CAP) return FRAME_CAP;
        return 32'(fb_reg);
    endfunction

    // Pointers, offsets, fill count and flags back to empty; store kept.
    function automatic void clear_ring();
        wr_slot  = '0;
        rd_slot  = '0;
        filled   = '0;
        wr_off   = '0;
        rd_off   = '0;
        rd_under = 1'b0;
        prev_act = ACT_WRITE;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_FRAME_BYTES: begin
                fb_reg = val;
                clear_ring();
            end
            CFG_FRAMES_KEPT: begin
                fk_reg = val[FRAMES_KEPT_W-1:0];
                clear_ring();
            end
            default: ;   // unmapped index: no effect at all
        endcase
    endfunction

    // Advances the predicted ring by one accepted word; returns 1 when the
    // word is a read and fills in the result it must produce.
    function automatic bit predict_ring(input logic act, input logic [7:0] d,
                                        output read_word_t w);
        int unsigned fb;
        int unsigned slots;
        fb    = frame_len();
        slots = fk_reg + 32'd1;
        w     = '0;

        // switching direction drops whatever partial frame the other side had
        if (act != prev_act) begin
            if (act == ACT_WRITE) begin
                rd_off   = '0;
                rd_under = 1'b0;
            end else begin
                wr_off = '0;
            end
        end
        prev_act = act;

        if (act == ACT_WRITE) begin
            ring_mem[{wr_slot, wr_off}] = d;
            if (wr_off + 32'd1 >= fb) begin
                // frame commits; on a full ring the oldest frame is dropped
                wr_off  = '0;
                wr_slot = 4'((wr_slot + 32'd1) % slots);
                if (filled + 32'd1 >= slots) begin
                    rd_slot = 4'((rd_slot + 32'd1) % slots);
                    filled  = 4'(slots - 32'd1);
                end else begin
                    filled = filled + 1'b1;
                end
            end else begin
                wr_off = wr_off + 1'b1;
            end
            return 1'b0;
        end

        // underrun is decided on the first byte of a read frame
        if (rd_off == 0) rd_under = (filled == 0);
        w.fend    = (rd_off + 32'd1 >= fb);
        w.under   = rd_under;
        w.rd_byte = rd_under ? 8'h00 : ring_mem[{rd_slot, rd_off}];
        if (w.fend) begin
            if (!rd_under) begin
                rd_slot = 4'((rd_slot + 32'd1) % slots);
                if (filled > 0) filled = filled - 1'b1;
            end
            rd_off = '0;
        end else begin
            rd_off = rd_off + 1'b1;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Plan row builders
    // ------------------------------------------------------------------
    function automatic plan_row_t word_row(input logic act, input logic [7:0] d);
        plan_row_t r;
        r        = '0;
        r.kind   = ROW_WORD;
        r.act    = act;
        r.data   = d;
        return r;
    endfunction

    // read whose result is known by inspection
    function automatic plan_row_t checked_read(input logic [7:0] b, input logic e,
                                               input logic u);
        plan_row_t r;
        r        = word_row(ACT_READ, 8'h00);
        r.typed  = 1'b1;
        r.x_word = '{rd_byte: b, fend: e, under: u};
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("mismatch @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Presents one word and holds it until accepted. Valid is left high so
    // a following word goes out back to back; the caller lowers it when idling.
    task automatic send_word(input logic act, input logic [7:0] d,
                             input bit typed, input read_word_t typed_w);
        read_word_t w;
        s_valid  <= 1'b1;
        s_action <= act;
        s_data   <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_words++;
        if (predict_ring(act, d, w)) expected_reads.push_back(typed ? typed_w : w);
    endtask

    // Random idle bursts between words, with stretches of none.
    task automatic sender_pause();
        if (calm) return;
        if (quiet_left > 0) begin
            quiet_left--;
            return;
        end
        case ($urandom_range(0, 9))
            0, 1: begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            2: quiet_left = $urandom_range(10, 60);
            default: ;
        endcase
    endtask

    // Stop sending until every expected read has come back, then let the
    // block finish any write word before returning.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_reads.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
        n_regs++;
    endtask

    // len words of one direction with random bytes
    task automatic send_frame(input logic act, input int unsigned len);
        repeat (len) begin
            send_word(act, 8'($urandom), 1'b0, '0);
            sender_pause();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, then quiet at the end
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        int unsigned span;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                span = $urandom_range(1, 14);
            end else begin
                m_ready <= 1'b1;
                span = $urandom_range(1, 40);
            end
            repeat (span - 1) @(posedge aclk);
        end
    end

    // Every accepted result is matched field by field against the oldest
    // expectation.
    always @(posedge aclk) begin : result_check
        read_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reads.size() == 0) begin
                report_mismatch($sformatf("read word %02h with nothing expected", m_read_byte));
            end else begin
                want = expected_reads.pop_front();
                n_checked++;
                if (m_underrun) n_under++;
                if (m_read_byte !== want.rd_byte)
                    report_mismatch($sformatf("read_byte %02h, want %02h",
                                              m_read_byte, want.rd_byte));
                if (m_frame_end !== want.fend)
                    report_mismatch($sformatf("frame_end %b, want %b", m_frame_end, want.fend));
                if (m_underrun !== want.under)
                    report_mismatch($sformatf("underrun %b, want %b", m_underrun, want.under));
            end
        end
    end

    // ------------------------------------------------------------------
    // Run limit: far beyond the slowest legal run (~600 words, each waiting
    // out a full sender gap and a full result stall, plus drains)
    // ------------------------------------------------------------------
    initial begin : watchdog
        #40_000_000;
        $display("timeout: %0d reads still outstanding", expected_reads.size());
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned base;
        int unsigned phase_start;
        int unsigned phase_len;
        logic [CFG_DATA_W-1:0]    fb_val;
        logic [FRAMES_KEPT_W-1:0] fk_val;

        fb_reg = FRAME_BYTES_RESET;
        fk_reg = FRAMES_KEPT_RESET;
        clear_ring();

        // Directed plan. Comments give the ring state after the row.
        plan = '{
            checked_read(8'h00, 1'b0, 1'b1),     // read on reset ring: underrun
            word_row(ACT_WRITE, 8'h00),          // drops that read, starts a 1024 B write
            reg_row(CFG_FRAME_BYTES, 13'd2),     // 2-byte frames
            reg_row(CFG_FRAMES_KEPT, 4'd1),      // two slots
            checked_read(8'h00, 1'b0, 1'b1),     // empty ring: underrun frame
            checked_read(8'h00, 1'b1, 1'b1),     //   ... its last byte
            word_row(ACT_WRITE, 8'h00),
            word_row(ACT_WRITE, 8'hFF),          // frame 00 FF commits
            word_row(ACT_WRITE, 8'h55),
            word_row(ACT_WRITE, 8'hAA),          // ring full: 00 FF dropped
            checked_read(8'h55, 1'b0, 1'b0),
            checked_read(8'hAA, 1'b1, 1'b0),     // ring empty again
            checked_read(8'h00, 1'b0, 1'b1),     // underrun
            word_row(ACT_WRITE, 8'h12),          // abandons read; partial write
            checked_read(8'h00, 1'b0, 1'b1),     // abandons write, nothing committed
            word_row(ACT_WRITE, 8'h34),
            word_row(ACT_WRITE, 8'h56),          // 34 56 commits
            word_row(ACT_READ, 8'hFF),           // half of 34 56
            word_row(ACT_WRITE, 8'h78),          // abandons that read
            word_row(ACT_WRITE, 8'h9A),          // full: 34 56 dropped
            word_row(ACT_READ, 8'h00),
            word_row(ACT_READ, 8'h00),           // 78 9A read out
            reg_row(CFG_FRAMES_KEPT, 4'd0),      // single slot
            word_row(ACT_WRITE, 8'hC3),
            word_row(ACT_WRITE, 8'h3C),          // commit dropped at once
            checked_read(8'h00, 1'b0, 1'b1),
            reg_row(CFG_FRAME_BYTES, 13'd0),     // zero length acts as one byte
            reg_row(CFG_FRAMES_KEPT, 4'd15),     // sixteen slots
            word_row(ACT_WRITE, 8'h81),          // one-byte frame commits
            reg_row(CFG_UNUSED_IDX, 13'h1FFF),   // unmapped index: ring untouched
            checked_read(8'h81, 1'b1, 1'b0),
            checked_read(8'h00, 1'b1, 1'b1)      // one-byte underrun frame
        };

        // synchronous reset, then release
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_word(plan[i].act, plan[i].data, plan[i].typed, plan[i].x_word);
                sender_pause();
            end
        end

        // Largest lengths: exact maximum, then a register value that saturates.
        // Partial frames only, so no last byte is reached and reads underrun.
        write_reg(CFG_FRAME_BYTES, 13'd4096);
        write_reg(CFG_FRAMES_KEPT, 4'd1);
        send_frame(ACT_WRITE, BIG_PART);
        send_frame(ACT_READ, BIG_PART);
        write_reg(CFG_FRAME_BYTES, 13'h1FFF);
        write_reg(CFG_FRAMES_KEPT, 4'd15);
        send_frame(ACT_WRITE, BIG_PART);
        send_frame(ACT_READ, BIG_PART);

        // Random phases: mostly whole frames at small sizes, some broken
        // frames, stray words and full drains mixed in.
        base = n_words;
        while (n_words - base < RANDOM_WORDS) begin
            case ($urandom_range(0, 19))
                0:       fb_val = 13'd0;
                1:       fb_val = 13'd1;
                2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                         fb_val = 13'($urandom_range(2, 6));
                default: fb_val = 13'($urandom_range(7, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       fk_val = 4'd0;
                1:       fk_val = 4'd15;
                default: fk_val = 4'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_FRAME_BYTES, fb_val);
                1: write_reg(CFG_FRAMES_KEPT, 13'(fk_val));
                2: begin
                    write_reg(CFG_FRAME_BYTES, fb_val);
                    write_reg(CFG_FRAMES_KEPT, 13'(fk_val));
                end
                default: begin
                    write_reg(CFG_FRAMES_KEPT, 13'(fk_val));
                    write_reg(CFG_FRAME_BYTES, fb_val);
                    write_reg(CFG_UNUSED_IDX, 13'($urandom));
                end
            endcase

            phase_len   = $urandom_range(30, 90);
            phase_start = n_words;
            while (n_words - phase_start < phase_len && n_words - base < RANDOM_WORDS) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8:
                        send_frame(ACT_WRITE, frame_len());
                    9, 10, 11, 12, 13, 14, 15:
                        send_frame(ACT_READ, frame_len());
                    16, 17:   // broken or complete frame, either direction
                        send_frame(1'($urandom), $urandom_range(1, frame_len()));
                    18: begin
                        send_word(1'($urandom), 8'($urandom), 1'b0, '0);
                        sender_pause();
                    end
                    default:  // hold off until every read is back
                        drain_results();
                endcase
                calm = (n_words - base) > (RANDOM_WORDS - CALM_TAIL);
            end
        end

        s_valid <= 1'b0;
        while (expected_reads.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("covered %0d words, %0d reads checked (%0d underrun), %0d register writes",
                 n_words, n_checked, n_under, n_regs);
        $display("whole frames of 1..40 bytes incl. zero length, partial frames at the maximum");
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
